/* sv/mi3_pkg.sv */
`default_nettype none
package mi3_pkg;

    localparam int FIELD_W       = 32;
    localparam int ELEM_W_DEF    = 32;
    localparam int FRAC_BITS_DEF = 16;

    // cofactor k = a[P]*a[Q] - a[R]*a[S], row-major element indices, already transposed
    localparam logic [3:0] COF_P [0:8] = '{4'd4, 4'd7, 4'd1, 4'd6, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
    localparam logic [3:0] COF_Q [0:8] = '{4'd8, 4'd2, 4'd5, 4'd5, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
    localparam logic [3:0] COF_R [0:8] = '{4'd7, 4'd1, 4'd4, 4'd3, 4'd6, 4'd0, 4'd6, 4'd0, 4'd3};
    localparam logic [3:0] COF_S [0:8] = '{4'd5, 4'd8, 4'd2, 4'd8, 4'd2, 4'd5, 4'd4, 4'd7, 4'd1};

    typedef struct packed {
        logic [FIELD_W-1:0] a00;
        logic [FIELD_W-1:0] a01;
        logic [FIELD_W-1:0] a02;
        logic [FIELD_W-1:0] a10;
        logic [FIELD_W-1:0] a11;
        logic [FIELD_W-1:0] a12;
        logic [FIELD_W-1:0] a20;
        logic [FIELD_W-1:0] a21;
        logic [FIELD_W-1:0] a22;
    } mat_word_t;

    typedef struct packed {
        logic [FIELD_W-1:0] b00;
        logic [FIELD_W-1:0] b01;
        logic [FIELD_W-1:0] b02;
        logic [FIELD_W-1:0] b10;
        logic [FIELD_W-1:0] b11;
        logic [FIELD_W-1:0] b12;
        logic [FIELD_W-1:0] b20;
        logic [FIELD_W-1:0] b21;
        logic [FIELD_W-1:0] b22;
        logic               singular;
        logic               saturated;
    } inv_word_t;

endpackage
`default_nettype wire

/* sv/mi3_div.sv */
`default_nettype none
module mi3_div #(
    parameter int NUM_W = 97,
    parameter int DEN_W = 99,
    parameter int Q_W   = 33
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0] den,
    output logic      [Q_W-1:0]   quo,
    output logic                  ovf
);

    localparam int RW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

    logic [RW-1:0]    rem_reg [0:Q_W-1];
    logic [DEN_W-1:0] den_reg [0:Q_W-1];
    logic [Q_W-1:0]   q_reg   [0:Q_W];
    logic             ovf_reg [0:Q_W];
    logic             ovf_next;

    // quotient too wide for Q_W bits
    assign ovf_next = RW'(num) >= (RW'(den) << Q_W);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= RW'(num);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= ovf_next;
        end
    end

    for (genvar k = 1; k <= Q_W; k++)
    begin : g_stage
        logic [RW-1:0]  sub_val;
        logic           ge;
        logic [Q_W-1:0] q_next;

        always_comb
        begin
            sub_val  = RW'(den_reg[k-1]) << (Q_W - k);
            ge       = rem_reg[k-1] >= sub_val;
            q_next   = q_reg[k-1];
            q_next[Q_W-k] = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k]   <= q_next;
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end

        if (k < Q_W)
        begin : g_rem
            logic [RW-1:0] rem_next;

            assign rem_next = ge ? rem_reg[k-1] - sub_val : rem_reg[k-1];

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    den_reg[k] <= den_reg[k-1];
                end
            end
        end
    end

    assign quo = q_reg[Q_W];
    assign ovf = ovf_reg[Q_W];

endmodule
`default_nettype wire

/* sv/matrix_inverse_3x3_core.sv */
// path: cofactor products, cofactors, determinant, divider operands, restoring divider, output register
// throughput: one matrix per cycle unless the output stalls; a restoring divider stage per quotient bit sets the depth
// a stall at the output freezes the whole pipeline, nothing lost or repeated
// reset: rst_n asynchronous, clears the valid bits only
`default_nettype none
module matrix_inverse_3x3_core #(
    parameter int ELEMENT_WIDTH = mi3_pkg::ELEM_W_DEF,
    parameter int FRACTION_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               a_valid,
    output logic                    a_ready,
    input  wire mi3_pkg::mat_word_t a_word,
    output logic                    inv_valid,
    input  wire logic               inv_ready,
    output mi3_pkg::inv_word_t      inv_word
);

    localparam int W       = ELEMENT_WIDTH;
    localparam int PW      = 2 * W;
    localparam int CW      = 2 * W + 1;
    localparam int HW      = 2 * W + 1;
    localparam int DETW    = 3 * W + 3;
    localparam int NW      = CW + 2 * FRACTION_BITS;
    localparam int QW      = W + 1;
    localparam int DIV_LAT = QW + 1;
    localparam int NST     = 6 + DIV_LAT;

    localparam logic [QW-1:0] LIM   = QW'(1) << (W - 1);
    localparam logic [QW-1:0] MAXP  = LIM - QW'(1);

    logic                  adv;
    logic [NST-1:0]        vld_reg;

    logic signed [W-1:0]   ain [0:8];

    logic signed [PW-1:0]  p1_reg [0:8];
    logic signed [PW-1:0]  p2_reg [0:8];
    logic signed [W-1:0]   a1_reg [0:2];
    logic signed [CW-1:0]  cof2_reg [0:8];
    logic signed [W-1:0]   a2_reg [0:2];
    logic signed [CW-1:0]  cof3_reg [0:8];
    logic signed [HW-1:0]  lo3_reg [0:2];
    logic signed [HW-1:0]  hi3_reg [0:2];
    logic signed [CW-1:0]  cof4_reg [0:8];
    logic signed [DETW-1:0] det4_reg;
    logic signed [DETW-1:0] det4_next;
    logic [NW-1:0]         num5_reg [0:8];
    logic [DETW-1:0]       den5_reg;
    logic                  zero5_reg;
    logic [8:0]            neg5_reg;
    logic [9:0]            side_reg [0:DIV_LAT-1];

    logic [QW-1:0]         quo [0:8];
    logic                  ovf [0:8];
    logic [W-1:0]          res [0:8];
    logic [8:0]            sat;
    mi3_pkg::inv_word_t    out_next;
    mi3_pkg::inv_word_t    out_reg;

    assign adv       = !vld_reg[NST-1] || inv_ready;
    assign a_ready   = adv;
    assign inv_valid = vld_reg[NST-1];
    assign inv_word  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NST-2:0], a_valid};
    end

    assign ain[0] = a_word.a00[W-1:0];
    assign ain[1] = a_word.a01[W-1:0];
    assign ain[2] = a_word.a02[W-1:0];
    assign ain[3] = a_word.a10[W-1:0];
    assign ain[4] = a_word.a11[W-1:0];
    assign ain[5] = a_word.a12[W-1:0];
    assign ain[6] = a_word.a20[W-1:0];
    assign ain[7] = a_word.a21[W-1:0];
    assign ain[8] = a_word.a22[W-1:0];

    // cofactors, transposed, each as a 2x2 cross product
    for (genvar i = 0; i < 9; i++)
    begin : g_cof
        logic signed [PW-1:0] p1_next;
        logic signed [PW-1:0] p2_next;

        assign p1_next = ain[mi3_pkg::COF_P[i]] * ain[mi3_pkg::COF_Q[i]];
        assign p2_next = ain[mi3_pkg::COF_R[i]] * ain[mi3_pkg::COF_S[i]];

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                p1_reg[i]   <= p1_next;
                p2_reg[i]   <= p2_next;
                cof2_reg[i] <= CW'(p1_reg[i]) - CW'(p2_reg[i]);
                cof3_reg[i] <= cof2_reg[i];
                cof4_reg[i] <= cof3_reg[i];
                num5_reg[i] <= NW'(cof4_reg[i][CW-1] ? -cof4_reg[i] : cof4_reg[i])
                               << (2 * FRACTION_BITS);
            end
        end
    end

    // determinant down column 0, cofactor split into high and low halves
    for (genvar k = 0; k < 3; k++)
    begin : g_det
        logic signed [HW-1:0] lo_next;
        logic signed [HW-1:0] hi_next;

        assign lo_next = a2_reg[k] * $signed({1'b0, cof2_reg[k][W-1:0]});
        assign hi_next = a2_reg[k] * $signed(cof2_reg[k][CW-1:W]);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                a1_reg[k]  <= ain[3 * k];
                a2_reg[k]  <= a1_reg[k];
                lo3_reg[k] <= lo_next;
                hi3_reg[k] <= hi_next;
            end
        end
    end

    always_comb
    begin
        det4_next = '0;
        for (int k = 0; k < 3; k++)
            det4_next = det4_next + (DETW'(hi3_reg[k]) << W) + DETW'(lo3_reg[k]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            det4_reg  <= det4_next;
            den5_reg  <= det4_reg[DETW-1] ? DETW'(-det4_reg) : DETW'(det4_reg);
            zero5_reg <= det4_reg == '0;
            for (int i = 0; i < 9; i++)
                neg5_reg[i] <= cof4_reg[i][CW-1] ^ det4_reg[DETW-1];
            side_reg[0] <= {zero5_reg, neg5_reg};
            for (int s = 1; s < DIV_LAT; s++)
                side_reg[s] <= side_reg[s-1];
            out_reg <= out_next;
        end
    end

    for (genvar i = 0; i < 9; i++)
    begin : g_div
        mi3_div #(
            .NUM_W (NW),
            .DEN_W (DETW),
            .Q_W   (QW)
        ) u_div (
            .clk (clk),
            .en  (adv),
            .num (num5_reg[i]),
            .den (den5_reg),
            .quo (quo[i]),
            .ovf (ovf[i])
        );

        // clamp and apply sign; zero determinant forces zero
        always_comb
        begin
            res[i] = '0;
            sat[i] = 1'b0;
            if (!side_reg[DIV_LAT-1][9])
            begin
                if (side_reg[DIV_LAT-1][i] && (ovf[i] || quo[i] != '0))
                begin
                    if (ovf[i] || quo[i] > LIM)
                    begin
                        res[i] = W'(-LIM);
                        sat[i] = 1'b1;
                    end
                    else
                        res[i] = W'(-quo[i]);
                end
                else if (ovf[i] || quo[i] > MAXP)
                begin
                    res[i] = W'(MAXP);
                    sat[i] = 1'b1;
                end
                else
                    res[i] = W'(quo[i]);
            end
        end
    end

    always_comb
    begin
        out_next.b00       = mi3_pkg::FIELD_W'($signed(res[0]));
        out_next.b01       = mi3_pkg::FIELD_W'($signed(res[1]));
        out_next.b02       = mi3_pkg::FIELD_W'($signed(res[2]));
        out_next.b10       = mi3_pkg::FIELD_W'($signed(res[3]));
        out_next.b11       = mi3_pkg::FIELD_W'($signed(res[4]));
        out_next.b12       = mi3_pkg::FIELD_W'($signed(res[5]));
        out_next.b20       = mi3_pkg::FIELD_W'($signed(res[6]));
        out_next.b21       = mi3_pkg::FIELD_W'($signed(res[7]));
        out_next.b22       = mi3_pkg::FIELD_W'($signed(res[8]));
        out_next.singular  = side_reg[DIV_LAT-1][9];
        out_next.saturated = |sat;
    end

    a_singular_clean: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv_word.singular |-> !inv_word.saturated && inv_word.b00 == '0
            && inv_word.b11 == '0 && inv_word.b22 == '0 && inv_word.b12 == '0)
        else $error("singular word carries non-zero data");

    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        inv_ready |-> a_ready)
        else $error("input blocked while output drains");

    a_sign_ext: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid |-> inv_word.b01 == mi3_pkg::FIELD_W'($signed(inv_word.b01[W-1:0])))
        else $error("element not sign-extended");

endmodule
`default_nettype wire

/* sim/tb_matrix_inverse_3x3_core.sv */
`timescale 1ns / 1ps
module tb_matrix_inverse_3x3_core;

    localparam int  PERIOD    = 12;
    localparam int  LATENCY   = mi3_pkg::ELEM_W_DEF + 8;
    localparam int  LIMIT     = 400000;
    localparam int  N_RANDOM  = 500;
    localparam int  QUIET_LO  = 560;
    localparam int  QUIET_HI  = 760;
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] MIN_EL = 32'h8000_0000;
    localparam logic [31:0] MAX_EL = 32'h7fff_ffff;
    localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

    typedef logic signed [159:0] wide_t;

    logic       clk;
    logic       rst_n;
    logic       a_valid;
    logic       a_ready;
    mi3_pkg::mat_word_t  a_word;
    logic       inv_valid;
    logic       inv_ready;
    mi3_pkg::inv_word_t  inv_word;

    mi3_pkg::mat_word_t  pending_mats[$];
    mi3_pkg::inv_word_t  expected_invs[$];
    int         cycle;
    int         errors;
    logic       mat_taken;
    int         hold_left;
    logic       stimulus_done;

    matrix_inverse_3x3_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .a_valid   (a_valid),
        .a_ready   (a_ready),
        .a_word    (a_word),
        .inv_valid (inv_valid),
        .inv_ready (inv_ready),
        .inv_word  (inv_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #(PERIOD / 2) clk = ~clk;
    end

    function automatic wide_t widen(logic [31:0] v);
        return {{128{v[31]}}, v};
    endfunction

    // adjugate over determinant, exact in wide signed arithmetic
    function automatic mi3_pkg::inv_word_t invert(mi3_pkg::mat_word_t m);
        wide_t e[9];
        wide_t c[9];
        wide_t det;
        wide_t q;
        logic [31:0] el[9];
        logic sat;
        mi3_pkg::inv_word_t r;
        e[0] = widen(m.a00); e[1] = widen(m.a01); e[2] = widen(m.a02);
        e[3] = widen(m.a10); e[4] = widen(m.a11); e[5] = widen(m.a12);
        e[6] = widen(m.a20); e[7] = widen(m.a21); e[8] = widen(m.a22);
        c[0] = e[4] * e[8] - e[7] * e[5];
        c[1] = -(e[1] * e[8] - e[7] * e[2]);
        c[2] = e[1] * e[5] - e[4] * e[2];
        c[3] = -(e[3] * e[8] - e[6] * e[5]);
        c[4] = e[0] * e[8] - e[6] * e[2];
        c[5] = -(e[0] * e[5] - e[3] * e[2]);
        c[6] = e[3] * e[7] - e[6] * e[4];
        c[7] = -(e[0] * e[7] - e[6] * e[1]);
        c[8] = e[0] * e[4] - e[3] * e[1];
        det = e[0] * c[0] + e[3] * c[1] + e[6] * c[2];
        sat = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            if (det == 0)
                el[k] = '0;
            else
            begin
                q = (c[k] <<< 32) / det;
                if (q > wide_t'(32'sh7fff_ffff))
                begin
                    el[k] = 32'h7fff_ffff;
                    sat = 1'b1;
                end
                else if (q < -wide_t'(64'sh8000_0000))
                begin
                    el[k] = 32'h8000_0000;
                    sat = 1'b1;
                end
                else
                    el[k] = q[31:0];
            end
        end
        r = {el[0], el[1], el[2], el[3], el[4], el[5], el[6], el[7], el[8],
             det == 0, sat};
        return r;
    endfunction

    function automatic mi3_pkg::mat_word_t mat(
        logic [31:0] m0, logic [31:0] m1, logic [31:0] m2,
        logic [31:0] m3, logic [31:0] m4, logic [31:0] m5,
        logic [31:0] m6, logic [31:0] m7, logic [31:0] m8);
        return {m0, m1, m2, m3, m4, m5, m6, m7, m8};
    endfunction

    // modest Q16.16 value, within +-8.0
    function automatic logic [31:0] modest();
        logic [31:0] v;
        v = $urandom_range(0, 32'h0008_0000);
        return ($urandom_range(0, 1) != 0) ? -v : v;
    endfunction

    function automatic logic [31:0] any_element();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 4) - 2;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        logic [31:0] r[9];
        stimulus_done = 1'b0;
        // identity, zero, scaled identity, negatives
        pending_mats.push_back(mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE));
        pending_mats.push_back(mat(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_mats.push_back(mat(-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE));
        pending_mats.push_back(mat(ONE << 1, 0, 0, 0, ONE << 2, 0, 0, 0, -(ONE << 3)));
        // extremes: rank one gives singular
        pending_mats.push_back(mat(MIN_EL, MIN_EL, MIN_EL, MIN_EL, MIN_EL, MIN_EL,
                                   MIN_EL, MIN_EL, MIN_EL));
        pending_mats.push_back(mat(MAX_EL, MAX_EL, MAX_EL, MAX_EL, MAX_EL, MAX_EL,
                                   MAX_EL, MAX_EL, MAX_EL));
        pending_mats.push_back(mat(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                                   ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES));
        pending_mats.push_back(mat(32'h8000_0000, 0, 0, 0, 32'h8000_0000, 0, 0, 0,
                                   32'h8000_0000));
        pending_mats.push_back(mat(32'h7fff_ffff, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0,
                                   32'h7fff_ffff));
        pending_mats.push_back(mat(32'h7fff_ffff, 32'h8000_0000, 0, 32'h8000_0000,
                                   32'h7fff_ffff, 32'h7fff_ffff, 0, 32'h8000_0000,
                                   32'h7fff_ffff));
        // tiny determinant: positive and negative saturation
        pending_mats.push_back(mat(1, 0, 0, 0, 1, 0, 0, 0, 1));
        pending_mats.push_back(mat(-1, 0, 0, 0, 1, 0, 0, 0, 1));
        pending_mats.push_back(mat(1, 1, 0, 0, 1, 0, 0, 0, 1));
        // exactly on the clamp edge and just past it
        pending_mats.push_back(mat(ONE >> 15, 0, 0, 0, ONE, 0, 0, 0, ONE));
        pending_mats.push_back(mat(-(ONE >> 15), 0, 0, 0, ONE, 0, 0, 0, ONE));
        // singular with a row repeated, then a mixed matrix and a permutation
        pending_mats.push_back(mat(ONE, 2, 3, ONE, 2, 3, 5, 6, 7));
        pending_mats.push_back(mat(3, ONE, -ONE, 7, 0, 9, 32'h1234_5678, 32'hdead_beef,
                                   32'h0bad_cafe));
        pending_mats.push_back(mat(0, ONE, 0, 0, 0, ONE, ONE, 0, 0));
        for (int n = 0; n < N_RANDOM; n++)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                    for (int k = 0; k < 9; k++) r[k] = modest();
                4, 5:
                    for (int k = 0; k < 9; k++) r[k] = $urandom;
                6:
                    for (int k = 0; k < 9; k++) r[k] = any_element();
                7:
                begin
                    for (int k = 0; k < 9; k++)
                        r[k] = (k % 4 == 0) ? modest() : $urandom_range(0, 7) - 4;
                end
                default:
                begin
                    // last row takes each element from row 0 or row 1, so it may repeat one of them
                    for (int k = 0; k < 6; k++) r[k] = any_element();
                    for (int k = 6; k < 9; k++) r[k] = r[k - 6 + 3 * $urandom_range(0, 1)];
                end
            endcase
            pending_mats.push_back(mat(r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8]));
        end
        stimulus_done = 1'b1;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // record acceptances at the rising edge
    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        mat_taken = a_valid && a_ready;
        if (mat_taken)
            expected_invs.push_back(invert(a_word));
    end

    initial
    begin
        cycle = 0;
        a_valid = 1'b0;
        a_word = '0;
        mat_taken = 1'b0;
    end

    // sender; quiet window with no idling between QUIET_LO and QUIET_HI
    always @(negedge clk)
    begin
        if (rst_n && (!a_valid || mat_taken))
        begin
            if (pending_mats.size() > 0 &&
                ((cycle >= QUIET_LO && cycle < QUIET_HI) || $urandom_range(0, 99) >= 24))
            begin
                a_word <= pending_mats.pop_front();
                a_valid <= 1'b1;
            end
            else
                a_valid <= 1'b0;
        end
    end

    // long hold-off count, so the pipeline backs up onto the input
    initial hold_left = 0;
    always @(negedge clk)
    begin
        if (cycle == 300 || cycle == 800)
            hold_left <= 200;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    initial inv_ready = 1'b0;
    always @(negedge clk)
    begin
        if (hold_left > 0)
            inv_ready <= 1'b0;
        else if (cycle >= QUIET_LO && cycle < QUIET_HI)
            inv_ready <= 1'b1;
        else
            inv_ready <= ($urandom_range(0, 99) >= 24);
    end

    // monitor
    initial errors = 0;
    always @(posedge clk)
    begin
        mi3_pkg::inv_word_t want;
        if (rst_n && inv_valid && inv_ready)
        begin
            if (expected_invs.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, inv_word);
                errors++;
            end
            else
            begin
                want = expected_invs.pop_front();
                for (int k = 0; k < 9; k++)
                    if (inv_word[289 - 32 * k -: 32] !== want[289 - 32 * k -: 32])
                    begin
                        $display("%0t: element b%0d%0d expected %h got %h", $time,
                                 k / 3, k % 3, want[289 - 32 * k -: 32],
                                 inv_word[289 - 32 * k -: 32]);
                        errors++;
                    end
                if (inv_word.singular !== want.singular)
                begin
                    $display("%0t: singular expected %b got %b", $time,
                             want.singular, inv_word.singular);
                    errors++;
                end
                if (inv_word.saturated !== want.saturated)
                begin
                    $display("%0t: saturated expected %b got %b", $time,
                             want.saturated, inv_word.saturated);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        fork
            begin
                wait (stimulus_done && pending_mats.size() == 0 && !a_valid
                      && expected_invs.size() == 0);
                repeat (LATENCY + 20) @(posedge clk);
                if (expected_invs.size() != 0)
                begin
                    $display("%0t: %0d words never arrived", $time, expected_invs.size());
                    errors++;
                end
                if (errors == 0)
                    $display("** matrix_inverse_3x3_core: PASSED **");
                else
                    $display("** matrix_inverse_3x3_core: FAILED **");
            end
            begin
                wait (cycle >= LIMIT);
                $display("%0t: timeout", $time);
                $display("** matrix_inverse_3x3_core: FAILED **");
            end
        join_any
        $finish;
    end

endmodule
